// ===== design/ghcp_pkg.sv =====
// Shared types and constants for the global history counter predictor.
// Field widths, register indexes and index-forming limits.
// No dependencies.
`timescale 1ns / 1ps

package ghcp_pkg;

    localparam int PcWidth      = 16;
    localparam int HistWidth    = 16;
    localparam int CountWidth   = 32;
    localparam int HistCfgWidth = 5;
    localparam int CtrCfgWidth  = 4;
    localparam int PcCfgWidth   = 5;
    localparam int CfgDataWidth = 5;
    localparam int CfgIdxWidth  = 2;

    // Largest history and address bit counts that take part in the index.
    localparam int HistLimit = 16;
    localparam int PcLimit   = 16;

    typedef logic [CfgIdxWidth-1:0] t_cfg_idx;
    typedef logic [CountWidth-1:0]  t_count;

    localparam t_cfg_idx CFG_HISTORY_BITS = 2'd0;
    localparam t_cfg_idx CFG_COUNTER_BITS = 2'd1;
    localparam t_cfg_idx CFG_PC_BITS      = 2'd2;

endpackage

// ===== design/global_history_counter_predictor_core.sv =====
// Global history correlating branch predictor with saturating counters.
// Counter table in one synchronous memory; uses ghcp_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// in        input      i_in_valid / o_in_stall       i_branch_pc_low, i_branch_taken
// out       output     o_out_valid / i_out_stall     o_predicted_taken .. o_correct_count
// cfg       input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// For each branch the transfer cycle issues the table read, and the update state
// (ST_CALC) then modifies the counter, writes it back and loads the output register.
// After reset a clearing pass writes zero to all 2**TABLE_INDEX_BITS entries, one
// per cycle; no branch is taken during it, configuration writes are.
// A stalled result holds the block in its update cycle until it is taken.
module global_history_counter_predictor_core #(
    parameter int TABLE_INDEX_BITS  = 12,
    parameter int MAX_COUNTER_WIDTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ghcp_pkg::PcWidth-1:0]         i_branch_pc_low,
    input  logic                                 i_branch_taken,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_predicted_taken,
    output logic                                 o_prediction_correct,
    output logic [ghcp_pkg::CountWidth-1:0]      o_branch_count,
    output logic [ghcp_pkg::CountWidth-1:0]      o_taken_count,
    output logic [ghcp_pkg::CountWidth-1:0]      o_fallthru_count,
    output logic [ghcp_pkg::CountWidth-1:0]      o_correct_count,
    input  logic                                 i_cfg_we,
    input  ghcp_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [ghcp_pkg::CfgDataWidth-1:0]    i_cfg_data
);

    localparam int Depth = 1 << TABLE_INDEX_BITS;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;

    logic [1:0]                          r_state;
    logic [TABLE_INDEX_BITS-1:0]         r_clr_addr;
    logic [TABLE_INDEX_BITS-1:0]         r_idx;
    logic                                r_taken;
    logic [MAX_COUNTER_WIDTH-1:0]        r_rdata;
    logic [ghcp_pkg::HistWidth-1:0]      r_hist;
    logic [ghcp_pkg::HistCfgWidth-1:0]   r_hist_bits;
    logic [ghcp_pkg::CtrCfgWidth-1:0]    r_ctr_bits;
    logic [ghcp_pkg::PcCfgWidth-1:0]     r_pc_bits;
    logic                                r_out_valid;
    logic                                r_pred;
    logic                                r_correct;
    ghcp_pkg::t_count                    r_branch_cnt;
    ghcp_pkg::t_count                    r_taken_cnt;
    ghcp_pkg::t_count                    r_fall_cnt;
    ghcp_pkg::t_count                    r_correct_cnt;

    logic [MAX_COUNTER_WIDTH-1:0]        mem [Depth];

    logic                                w_in_xfer;
    logic                                w_load;
    logic [ghcp_pkg::HistCfgWidth-1:0]   w_m_eff;
    logic [ghcp_pkg::PcCfgWidth-1:0]     w_k_eff;
    logic [ghcp_pkg::CtrCfgWidth-1:0]    w_n_eff;
    logic [ghcp_pkg::HistWidth-1:0]      w_hmask;
    logic [ghcp_pkg::PcWidth-1:0]        w_pmask;
    logic [ghcp_pkg::HistWidth-1:0]      w_hist_m;
    logic [31:0]                         w_idx_wide;
    logic [TABLE_INDEX_BITS-1:0]         w_idx;
    logic [ghcp_pkg::HistWidth-1:0]      n_hist;
    logic [MAX_COUNTER_WIDTH-1:0]        w_cmax;
    logic [MAX_COUNTER_WIDTH-1:0]        w_ctr;
    logic [MAX_COUNTER_WIDTH-1:0]        n_ctr;
    logic                                w_pred;
    logic                                w_correct;
    logic                                w_mem_we;
    logic [TABLE_INDEX_BITS-1:0]         w_mem_addr;
    logic [MAX_COUNTER_WIDTH-1:0]        w_mem_wdata;

    assign w_in_xfer = i_in_valid && !o_in_stall;
    assign w_load    = (r_state == ST_CALC) && (!r_out_valid || !i_out_stall);

    // Effective configuration after limiting.
    always_comb begin
        w_m_eff = (int'(r_hist_bits) > ghcp_pkg::HistLimit) ?
                  ghcp_pkg::HistCfgWidth'(ghcp_pkg::HistLimit) : r_hist_bits;
        w_k_eff = (int'(r_pc_bits) > ghcp_pkg::PcLimit) ?
                  ghcp_pkg::PcCfgWidth'(ghcp_pkg::PcLimit) : r_pc_bits;
        if (r_ctr_bits == '0) begin
            w_n_eff = ghcp_pkg::CtrCfgWidth'(1);
        end else if (int'(r_ctr_bits) > MAX_COUNTER_WIDTH) begin
            w_n_eff = ghcp_pkg::CtrCfgWidth'(MAX_COUNTER_WIDTH);
        end else begin
            w_n_eff = r_ctr_bits;
        end
    end

    always_comb begin
        for (int i = 0; i < ghcp_pkg::HistWidth; i++) begin
            w_hmask[i] = (i < int'(w_m_eff));
        end
        for (int i = 0; i < ghcp_pkg::PcWidth; i++) begin
            w_pmask[i] = (i < int'(w_k_eff));
        end
        for (int i = 0; i < MAX_COUNTER_WIDTH; i++) begin
            w_cmax[i] = (i < int'(w_n_eff));
        end
    end

    // Table index and next history, formed in the transfer cycle.
    always_comb begin
        w_hist_m   = r_hist & w_hmask;
        w_idx_wide = (32'(w_hist_m) << w_k_eff) | 32'(i_branch_pc_low & w_pmask);
        w_idx      = w_idx_wide[TABLE_INDEX_BITS-1:0];
        n_hist     = {w_hist_m[ghcp_pkg::HistWidth-2:0], i_branch_taken} & w_hmask;
    end

    // Counter update from the registered read data.
    always_comb begin
        w_ctr     = (r_rdata > w_cmax) ? w_cmax : r_rdata;
        w_pred    = (w_ctr > (w_cmax >> 1));
        w_correct = (w_pred == r_taken);
        if (r_taken) begin
            n_ctr = (w_ctr != w_cmax) ? w_ctr + 1'b1 : w_ctr;
        end else begin
            n_ctr = (w_ctr != '0) ? w_ctr - 1'b1 : w_ctr;
        end
    end

    always_comb begin
        w_mem_we    = (r_state == ST_CLEAR) || w_load;
        w_mem_addr  = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
        w_mem_wdata = (r_state == ST_CLEAR) ? '0 : n_ctr;
    end

    // The read data is held while the update cycle waits on a stalled result.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_in_xfer) begin
            r_rdata <= mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_hist      <= '0;
            r_hist_bits <= '0;
            r_ctr_bits  <= ghcp_pkg::CtrCfgWidth'(1);
            r_pc_bits   <= '0;
            r_out_valid <= 1'b0;
            r_branch_cnt  <= '0;
            r_taken_cnt   <= '0;
            r_fall_cnt    <= '0;
            r_correct_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ghcp_pkg::CFG_HISTORY_BITS: r_hist_bits <= i_cfg_data;
                    ghcp_pkg::CFG_COUNTER_BITS:
                        r_ctr_bits <= i_cfg_data[ghcp_pkg::CtrCfgWidth-1:0];
                    ghcp_pkg::CFG_PC_BITS:      r_pc_bits <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {TABLE_INDEX_BITS{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_hist  <= n_hist;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (w_load) begin
                        r_out_valid  <= 1'b1;
                        r_branch_cnt <= r_branch_cnt + 1'b1;
                        if (r_taken) begin
                            r_taken_cnt <= r_taken_cnt + 1'b1;
                        end else begin
                            r_fall_cnt <= r_fall_cnt + 1'b1;
                        end
                        if (w_correct) begin
                            r_correct_cnt <= r_correct_cnt + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_idx   <= w_idx;
            r_taken <= i_branch_taken;
        end
        if (w_load) begin
            r_pred    <= w_pred;
            r_correct <= w_correct;
        end
    end

    assign o_in_stall           = (r_state != ST_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_predicted_taken    = r_pred;
    assign o_prediction_correct = r_correct;
    assign o_branch_count       = r_branch_cnt;
    assign o_taken_count        = r_taken_cnt;
    assign o_fallthru_count     = r_fall_cnt;
    assign o_correct_count      = r_correct_cnt;

`ifndef ASSERT_OFF
    a_xfer_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_CALC))
        else $error("accepted branch did not move to the update cycle");

    a_count_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_branch_cnt == ghcp_pkg::CountWidth'(r_taken_cnt + r_fall_cnt))
        else $error("branch count differs from taken plus fall-through counts");

    a_load_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_CALC))
        else $error("result appeared without an update cycle");

    a_no_xfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !w_in_xfer)
        else $error("branch transferred during the clearing pass");

    a_stall_holds_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_branch_cnt))
        else $error("counts changed while a result was stalled");
`endif

endmodule

// ===== tb/sv/global_history_counter_predictor_core_tb.sv =====
// Self-checking testbench for the global history counter predictor core.
// Drives resolved branches and register writes and checks results against its own predictor.
// Depends on ghcp_pkg and global_history_counter_predictor_core.
`timescale 1ns / 1ps

module global_history_counter_predictor_core_tb;

    localparam int TableIndexBits  = 12;
    localparam int MaxCounterWidth = 8;
    localparam int TableDepth      = 1 << TableIndexBits;
    localparam int ClkHalf         = 6;
    localparam int MaxReported     = 10;
    localparam int HoldOffCycles   = 400;
    localparam int PoolSize        = 8;

    // Index 3 is outside the register list and must be ignored.
    localparam ghcp_pkg::t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             predicted;
        logic             correct;
        ghcp_pkg::t_count branches;
        ghcp_pkg::t_count takens;
        ghcp_pkg::t_count fallthrus;
        ghcp_pkg::t_count corrects;
    } t_branch_outcome;

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_in_valid      = 1'b0;
    logic                              o_in_stall;
    logic [ghcp_pkg::PcWidth-1:0]      i_branch_pc_low = '0;
    logic                              i_branch_taken  = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall     = 1'b0;
    logic                              o_predicted_taken;
    logic                              o_prediction_correct;
    ghcp_pkg::t_count                  o_branch_count;
    ghcp_pkg::t_count                  o_taken_count;
    ghcp_pkg::t_count                  o_fallthru_count;
    ghcp_pkg::t_count                  o_correct_count;
    logic                              i_cfg_we        = 1'b0;
    ghcp_pkg::t_cfg_idx                i_cfg_index     = ghcp_pkg::CFG_HISTORY_BITS;
    logic [ghcp_pkg::CfgDataWidth-1:0] i_cfg_data      = '0;

    // Predictor state and its copy of the registers.
    logic [ghcp_pkg::HistCfgWidth-1:0] hist_len_cfg;
    logic [ghcp_pkg::CtrCfgWidth-1:0]  ctr_width_cfg;
    logic [ghcp_pkg::PcCfgWidth-1:0]   pc_len_cfg;
    logic [MaxCounterWidth-1:0]        pattern_table [TableDepth];
    logic [ghcp_pkg::HistWidth-1:0]    global_hist;
    ghcp_pkg::t_count                  branches_seen;
    ghcp_pkg::t_count                  taken_seen;
    ghcp_pkg::t_count                  fallthru_seen;
    ghcp_pkg::t_count                  correct_seen;

    t_branch_outcome outcome_q [$];
    int unsigned     error_count   = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     out_stall_pct = 0;
    int unsigned     hold_token    = 0;
    int unsigned     hold_seen     = 0;
    int unsigned     hold_left     = 0;

    global_history_counter_predictor_core #(
        .TABLE_INDEX_BITS  (TableIndexBits),
        .MAX_COUNTER_WIDTH (MaxCounterWidth)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_branch_pc_low      (i_branch_pc_low),
        .i_branch_taken       (i_branch_taken),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_predicted_taken    (o_predicted_taken),
        .o_prediction_correct (o_prediction_correct),
        .o_branch_count       (o_branch_count),
        .o_taken_count        (o_taken_count),
        .o_fallthru_count     (o_fallthru_count),
        .o_correct_count      (o_correct_count),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        forever #ClkHalf i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void clear_predictor();
        hist_len_cfg  = '0;
        ctr_width_cfg = ghcp_pkg::CtrCfgWidth'(1);
        pc_len_cfg    = '0;
        for (int i = 0; i < TableDepth; i++) begin
            pattern_table[i] = '0;
        end
        global_hist   = '0;
        branches_seen = '0;
        taken_seen    = '0;
        fallthru_seen = '0;
        correct_seen  = '0;
    endfunction

    // Looks up the counter selected by history and address, then trains it.
    function automatic t_branch_outcome predict_and_train(
        input logic [ghcp_pkg::PcWidth-1:0] pc,
        input logic taken);
        int unsigned     m;
        int unsigned     k;
        int unsigned     n;
        logic [31:0]     hist;
        logic [31:0]     idx;
        logic [31:0]     cmax;
        logic [31:0]     ctr;
        t_branch_outcome r;
        m = (hist_len_cfg > ghcp_pkg::HistLimit) ? ghcp_pkg::HistLimit : hist_len_cfg;
        k = (pc_len_cfg > ghcp_pkg::PcLimit) ? ghcp_pkg::PcLimit : pc_len_cfg;
        if (ctr_width_cfg == 0) begin
            n = 1;
        end else if (ctr_width_cfg > MaxCounterWidth) begin
            n = MaxCounterWidth;
        end else begin
            n = ctr_width_cfg;
        end
        hist = 32'(global_hist) & ((32'd1 << m) - 32'd1);
        idx  = ((hist << k) | (32'(pc) & ((32'd1 << k) - 32'd1))) & 32'(TableDepth - 1);
        cmax = (32'd1 << n) - 32'd1;
        ctr  = 32'(pattern_table[idx]);
        // A counter left over from a wider setting saturates at the new maximum.
        if (ctr > cmax) begin
            ctr = cmax;
        end
        r.predicted = (ctr > (cmax >> 1));
        r.correct   = (r.predicted == taken);
        branches_seen += 1;
        if (r.correct) begin
            correct_seen += 1;
        end
        if (taken) begin
            taken_seen += 1;
            if (ctr != cmax) begin
                ctr += 1;
            end
        end else begin
            fallthru_seen += 1;
            if (ctr != 0) begin
                ctr -= 1;
            end
        end
        pattern_table[idx] = ctr[MaxCounterWidth-1:0];
        global_hist = ghcp_pkg::HistWidth'(((hist << 1) | 32'(taken)) &
                                           ((32'd1 << m) - 32'd1));
        r.branches  = branches_seen;
        r.takens    = taken_seen;
        r.fallthrus = fallthru_seen;
        r.corrects  = correct_seen;
        return r;
    endfunction

    task automatic send_branch(input logic [ghcp_pkg::PcWidth-1:0] pc, input logic taken);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_branch_pc_low <= pc;
        i_branch_taken  <= taken;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        outcome_q.push_back(predict_and_train(pc, taken));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Caller makes sure the block is idle first.
    task automatic write_reg(input ghcp_pkg::t_cfg_idx idx,
                             input logic [ghcp_pkg::CfgDataWidth-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            ghcp_pkg::CFG_HISTORY_BITS: hist_len_cfg  = value[ghcp_pkg::HistCfgWidth-1:0];
            ghcp_pkg::CFG_COUNTER_BITS: ctr_width_cfg = value[ghcp_pkg::CtrCfgWidth-1:0];
            ghcp_pkg::CFG_PC_BITS:      pc_len_cfg    = value[ghcp_pkg::PcCfgWidth-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [ghcp_pkg::CfgDataWidth-1:0] hist_len,
                                  input logic [ghcp_pkg::CfgDataWidth-1:0] ctr_width,
                                  input logic [ghcp_pkg::CfgDataWidth-1:0] pc_len);
        wait_results_drained();
        write_reg(ghcp_pkg::CFG_HISTORY_BITS, hist_len);
        write_reg(ghcp_pkg::CFG_COUNTER_BITS, ctr_width);
        write_reg(ghcp_pkg::CFG_PC_BITS, pc_len);
    endtask

    task automatic test_default_config();
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_branch(16'h0000, 1'b0);
        send_branch(16'hFFFF, 1'b1);
        send_branch(16'hFFFF, 1'b1);
        send_branch(16'h0000, 1'b0);
    endtask

    task automatic test_config_extremes();
        // Out-of-range widths act as the largest legal ones.
        write_all_regs(5'd31, 5'd15, 5'd31);
        send_branch(16'hA5A5, 1'b1);
        send_branch(16'h5A5A, 1'b0);
        send_branch(16'hFFFF, 1'b1);
        // Bit 4 is dropped, so this is a zero counter width, which acts as one.
        wait_results_drained();
        write_reg(ghcp_pkg::CFG_COUNTER_BITS, 5'h10);
        write_reg(CFG_UNUSED, 5'h1F);
        send_branch(16'h1234, 1'b1);
        send_branch(16'h1234, 1'b0);
    endtask

    task automatic test_counter_clamp();
        write_all_regs(5'd0, 5'd2, 5'd0);
        repeat (3) send_branch(16'h0000, 1'b1);
        // The counter now sits at 3; with one-bit counters it reads as 1.
        wait_results_drained();
        write_reg(ghcp_pkg::CFG_COUNTER_BITS, 5'd1);
        send_branch(16'h0000, 1'b0);
        send_branch(16'h0000, 1'b0);
    endtask

    task automatic test_history_narrowing();
        write_all_regs(5'd16, 5'd2, 5'd4);
        send_branch(16'h0003, 1'b1);
        send_branch(16'h0007, 1'b1);
        send_branch(16'h0003, 1'b0);
        send_branch(16'h000F, 1'b1);
        wait_results_drained();
        write_reg(ghcp_pkg::CFG_HISTORY_BITS, 5'd2);
        send_branch(16'h0003, 1'b1);
        send_branch(16'hFFF3, 1'b0);
        send_branch(16'h0003, 1'b1);
    endtask

    // The receiver holds off while branches keep coming, so the input must stall.
    task automatic test_output_backpressure();
        write_all_regs(5'd8, 5'd3, 5'd4);
        hold_token <= hold_token + 1;
        repeat (16) send_branch(ghcp_pkg::PcWidth'($urandom), 1'($urandom));
        wait_results_drained();
    endtask

    task automatic run_traffic_chunk(input int unsigned n_items);
        logic [ghcp_pkg::PcWidth-1:0]      pc_pool   [PoolSize];
        int unsigned                       bias_pool [PoolSize];
        int unsigned                       sel;
        logic [ghcp_pkg::CfgDataWidth-1:0] hist_len;
        logic [ghcp_pkg::CfgDataWidth-1:0] ctr_width;
        logic [ghcp_pkg::CfgDataWidth-1:0] pc_len;
        case ($urandom_range(3))
            0:       hist_len = 5'd0;
            1:       hist_len = 5'd16;
            2:       hist_len = 5'($urandom_range(17, 31));
            default: hist_len = 5'($urandom_range(1, 15));
        endcase
        case ($urandom_range(3))
            0:       ctr_width = 5'd1;
            1:       ctr_width = 5'd8;
            2:       ctr_width = 5'($urandom_range(31));
            default: ctr_width = 5'($urandom_range(2, 7));
        endcase
        case ($urandom_range(3))
            0:       pc_len = 5'd0;
            1:       pc_len = 5'd16;
            2:       pc_len = 5'($urandom_range(17, 31));
            default: pc_len = 5'($urandom_range(1, 15));
        endcase
        write_all_regs(hist_len, ctr_width, pc_len);
        // A few hot branches with steady bias let the counters train like real loops.
        for (int i = 0; i < PoolSize; i++) begin
            pc_pool[i] = ghcp_pkg::PcWidth'($urandom);
            case ($urandom_range(2))
                0:       bias_pool[i] = 5;
                1:       bias_pool[i] = 95;
                default: bias_pool[i] = 50;
            endcase
        end
        for (int unsigned i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 75) begin
                sel = $urandom_range(PoolSize - 1);
                send_branch(pc_pool[sel], ($urandom_range(99) < bias_pool[sel]));
            end else begin
                send_branch(ghcp_pkg::PcWidth'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned idle_set  [4] = '{0, 82, 0, 19};
        int unsigned stall_set [4] = '{0, 0, 82, 19};
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 3; c++) begin
                wait_results_drained();
                send_idle_pct = idle_set[p];
                out_stall_pct = stall_set[p];
                run_traffic_chunk(125);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HoldOffCycles;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_branch_outcome want;
        t_branch_outcome got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_predicted_taken, o_prediction_correct, o_branch_count,
                    o_taken_count, o_fallthru_count, o_correct_count};
            if (outcome_q.size() == 0) begin
                if (error_count < MaxReported) begin
                    $display("Unexpected result transfer at %0t", $realtime);
                end
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got !== want) begin
                    if (error_count < MaxReported) begin
                        $display({"Mismatch at %0t: expected ",
                                  "pred=%0d ok=%0d br=%0d tk=%0d ft=%0d cr=%0d"},
                                 $realtime, want.predicted, want.correct, want.branches,
                                 want.takens, want.fallthrus, want.corrects);
                        $display({"                 actual   ",
                                  "pred=%0d ok=%0d br=%0d tk=%0d ft=%0d cr=%0d"},
                                 got.predicted, got.correct, got.branches,
                                 got.takens, got.fallthrus, got.corrects);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        clear_predictor();
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_config_extremes();
        test_counter_clamp();
        test_history_narrowing();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
